// ----- hw/rtl/itpc_pkg.sv -----
// ----------------------------------------------------------------------------
// itpc_pkg - shared types and helpers for the infix to postfix converter
// Character classes, stack codes, priorities and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package itpc_pkg;

    localparam int unsigned DEF_STACK_DEPTH = 32;

    typedef logic [7:0] sym_t;
    typedef logic [1:0] fault_t;
    typedef logic [2:0] op_code_t;
    typedef logic [1:0] prio_t;

    localparam sym_t CH_ADD   = 8'h2B;
    localparam sym_t CH_SUB   = 8'h2D;
    localparam sym_t CH_MUL   = 8'h2A;
    localparam sym_t CH_DIV   = 8'h2F;
    localparam sym_t CH_OPEN  = 8'h28;
    localparam sym_t CH_CLOSE = 8'h29;
    localparam sym_t CH_NONE  = 8'h00;

    localparam op_code_t CODE_ADD  = 3'd0;
    localparam op_code_t CODE_SUB  = 3'd1;
    localparam op_code_t CODE_MUL  = 3'd2;
    localparam op_code_t CODE_DIV  = 3'd3;
    localparam op_code_t CODE_OPEN = 3'd4;

    localparam fault_t FAULT_NONE      = 2'd0;
    localparam fault_t FAULT_UNMATCHED = 2'd1;
    localparam fault_t FAULT_OVERFLOW  = 2'd2;

    localparam prio_t PRIO_OPEN = 2'd1;
    localparam prio_t PRIO_ADD  = 2'd2;
    localparam prio_t PRIO_MUL  = 2'd3;

    typedef enum logic [1:0] {
        CLS_OTHER,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_OPER
    } sym_class_t;

    typedef enum logic [1:0] {
        EMIT_SYM,
        EMIT_TOP,
        EMIT_UNMATCHED,
        EMIT_OVERFLOW
    } emit_sel_t;

    typedef struct packed {
        logic      load;
        logic      rd;
        logic      pop;
        logic      push;
        logic      emit;
        emit_sel_t emit_sel;
        logic      finish;
    } dp_cmd_t;

    typedef struct packed {
        sym_class_t cls;
        logic       fin;
        logic       empty;
        logic       full;
        logic       top_open;
        logic       top_ge;
        logic       can_emit;
    } dp_stat_t;

    function automatic sym_class_t sym_class(input sym_t s);
        sym_class_t c;
        begin
            unique case (s) inside
                CH_OPEN:                         c = CLS_OPEN;
                CH_CLOSE:                        c = CLS_CLOSE;
                CH_ADD, CH_SUB, CH_MUL, CH_DIV:  c = CLS_OPER;
                default:                         c = CLS_OTHER;
            endcase
            return c;
        end
    endfunction

    // stack code of an operator or open bracket
    function automatic op_code_t sym_code(input sym_t s);
        op_code_t c;
        begin
            unique case (s)
                CH_OPEN: c = CODE_OPEN;
                CH_ADD:  c = CODE_ADD;
                CH_SUB:  c = CODE_SUB;
                CH_MUL:  c = CODE_MUL;
                default: c = CODE_DIV;
            endcase
            return c;
        end
    endfunction

    function automatic prio_t code_prio(input op_code_t c);
        prio_t p;
        begin
            unique case (c) inside
                CODE_OPEN:          p = PRIO_OPEN;
                CODE_MUL, CODE_DIV: p = PRIO_MUL;
                default:            p = PRIO_ADD;
            endcase
            return p;
        end
    endfunction

    function automatic sym_t code_char(input op_code_t c);
        sym_t s;
        begin
            unique case (c)
                CODE_ADD:  s = CH_ADD;
                CODE_SUB:  s = CH_SUB;
                CODE_MUL:  s = CH_MUL;
                CODE_DIV:  s = CH_DIV;
                CODE_OPEN: s = CH_OPEN;
                default:   s = CH_NONE;
            endcase
            return s;
        end
    endfunction

endpackage

// ----- hw/rtl/itpc_sym_if.sv -----
// ----------------------------------------------------------------------------
// itpc_sym_if - input character channel
// One infix character per request, with the end-of-expression mark.
// ----------------------------------------------------------------------------
interface itpc_sym_if;
    logic            valid;
    logic            ready;
    itpc_pkg::sym_t  symbol;
    logic            final_char;

    modport source (output valid, output symbol, output final_char, input ready);
    modport sink   (input valid, input symbol, input final_char, output ready);
endinterface

// ----- hw/rtl/itpc_res_if.sv -----
// ----------------------------------------------------------------------------
// itpc_res_if - result channel
// One postfix character or fault report per request.
// ----------------------------------------------------------------------------
interface itpc_res_if;
    logic              valid;
    logic              ready;
    itpc_pkg::sym_t    out_symbol;
    itpc_pkg::fault_t  fault;
    logic              run_end;
    logic              expression_end;

    modport source (output valid, output out_symbol, output fault, output run_end,
                    output expression_end, input ready);
    modport sink   (input valid, input out_symbol, input fault, input run_end,
                    input expression_end, output ready);
endinterface

// ----- hw/rtl/infix_to_postfix_converter_unit.sv -----
// Path: a plain character's result goes from the symbol register to the hold stage, then the output register.
// Pacing: a new character is taken only once the last one is finished; each stack entry popped
// and issued takes a memory read then a pop; a pop loop stops on a remaining entry or a matched open bracket.
// Reset: asynchronous, active low; clears stack count, held result and output valid.
// Stack contents are not cleared; only entries below the count are ever read.
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit - shunting-yard infix to postfix converter
// Takes one infix character per request and issues the postfix characters it
// releases, with fault reports for an unmatched close bracket and a full stack.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit #(
    parameter int unsigned STACK_DEPTH = itpc_pkg::DEF_STACK_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    itpc_sym_if.sink   sym_ch,
    itpc_res_if.source res_ch
);
    import itpc_pkg::*;

    // Controller and datapath talk only through these bundles.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer: one character at a time. Per character it decodes the class,
    // loops over top-of-stack reads and pops for close brackets and operators,
    // pushes, then on the last character of an expression flushes the stack.
    itpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sym_ch.valid),
        .in_ready (sym_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: stack memory and count, a one-deep hold stage so the last
    // result of a character can carry the run and expression end marks, and
    // the output register, which lets a new request in while a result waits.
    itpc_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .symbol     (sym_ch.symbol),
        .final_char (sym_ch.final_char),
        .cmd        (cmd),
        .stat       (stat),
        .res_ch     (res_ch)
    );

endmodule

// ----- hw/rtl/itpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// itpc_ctrl - converter sequencer
// Walks one character through decode, stack pops, push and flush.
// ----------------------------------------------------------------------------
module itpc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  itpc_pkg::dp_stat_t stat,
    output itpc_pkg::dp_cmd_t  cmd
);
    import itpc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_TOP    = 5'b00100,
        S_TAIL   = 5'b01000,
        S_FLUSH  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.cls)
                    CLS_OTHER:
                    begin
                        if (stat.can_emit)
                        begin
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = EMIT_SYM;
                            state_next   = S_TAIL;
                        end
                    end
                    CLS_OPEN:
                    begin
                        if (!stat.full)
                        begin
                            cmd.push   = 1'b1;
                            state_next = S_TAIL;
                        end
                        else if (stat.can_emit)
                        begin
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = EMIT_OVERFLOW;
                            state_next   = S_TAIL;
                        end
                    end
                    default:
                    begin
                        // close bracket or operator: look at the top first
                        if (!stat.empty)
                        begin
                            cmd.rd     = 1'b1;
                            state_next = S_TOP;
                        end
                        else if (stat.cls == CLS_OPER)
                        begin
                            cmd.push   = 1'b1;
                            state_next = S_TAIL;
                        end
                        else if (stat.can_emit)
                        begin
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = EMIT_UNMATCHED;
                            state_next   = S_TAIL;
                        end
                    end
                endcase
            end
            S_TOP:
            begin
                if (stat.cls == CLS_CLOSE && stat.top_open)
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_TAIL;
                end
                else if (stat.cls == CLS_CLOSE || stat.top_ge)
                begin
                    if (stat.can_emit)
                    begin
                        cmd.pop      = 1'b1;
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = EMIT_TOP;
                        state_next   = S_DECODE;
                    end
                end
                else if (!stat.full)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_TAIL;
                end
                else if (stat.can_emit)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_OVERFLOW;
                    state_next   = S_TAIL;
                end
            end
            S_TAIL:
            begin
                if (stat.fin && !stat.empty)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_FLUSH;
                end
                else if (stat.can_emit)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (stat.can_emit)
                begin
                    cmd.pop      = 1'b1;
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_TOP;
                    state_next   = S_TAIL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/itpc_dpath.sv -----
// ----------------------------------------------------------------------------
// itpc_dpath - converter datapath
// Operator stack memory, stack count, held result and output register.
// ----------------------------------------------------------------------------
module itpc_dpath #(
    parameter int unsigned STACK_DEPTH = itpc_pkg::DEF_STACK_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  itpc_pkg::sym_t     symbol,
    input  logic               final_char,
    input  itpc_pkg::dp_cmd_t  cmd,
    output itpc_pkg::dp_stat_t stat,
    itpc_res_if.source         res_ch
);
    import itpc_pkg::*;

    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] COUNT_ONE  = CW'(1);

    op_code_t      stack_mem [STACK_DEPTH];
    op_code_t      rd_reg;
    sym_t          sym_reg;
    logic          fin_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] top_addr;

    // one result is held back until it is known whether another follows
    logic   pend_valid_reg;
    logic   pend_valid_next;
    sym_t   pend_sym_reg;
    fault_t pend_fault_reg;

    logic   out_valid_reg;
    logic   out_valid_next;
    sym_t   out_sym_reg;
    fault_t out_fault_reg;
    logic   out_run_end_reg;
    logic   out_expr_end_reg;

    sym_t     new_sym;
    fault_t   new_fault;
    op_code_t in_code;
    logic     move;

    assign in_code  = sym_code(sym_reg);
    assign top_addr = count_reg - COUNT_ONE;
    assign move     = (cmd.emit || cmd.finish) && pend_valid_reg;

    always_comb
    begin
        case (cmd.emit_sel)
            EMIT_SYM:
            begin
                new_sym   = sym_reg;
                new_fault = FAULT_NONE;
            end
            EMIT_TOP:
            begin
                new_sym   = code_char(rd_reg);
                new_fault = FAULT_NONE;
            end
            EMIT_UNMATCHED:
            begin
                new_sym   = CH_NONE;
                new_fault = FAULT_UNMATCHED;
            end
            default:
            begin
                new_sym   = CH_NONE;
                new_fault = FAULT_OVERFLOW;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + COUNT_ONE;
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - COUNT_ONE;
        end

        pend_valid_next = pend_valid_reg;
        if (cmd.emit)
        begin
            pend_valid_next = 1'b1;
        end
        else if (cmd.finish)
        begin
            pend_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            fin_reg        <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cmd.load)
            begin
                fin_reg <= final_char;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sym_reg <= symbol;
        end
        if (cmd.emit)
        begin
            pend_sym_reg   <= new_sym;
            pend_fault_reg <= new_fault;
        end
        if (move)
        begin
            out_sym_reg      <= pend_sym_reg;
            out_fault_reg    <= pend_fault_reg;
            out_run_end_reg  <= cmd.finish;
            out_expr_end_reg <= cmd.finish & fin_reg;
        end
    end

    // stack memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_mem[count_reg[AW-1:0]] <= (sym_reg == CH_OPEN) ? CODE_OPEN : in_code;
        end
        if (cmd.rd)
        begin
            rd_reg <= stack_mem[top_addr[AW-1:0]];
        end
    end

    assign stat.cls      = sym_class(sym_reg);
    assign stat.fin      = fin_reg;
    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == COUNT_FULL);
    assign stat.top_open = (rd_reg == CODE_OPEN);
    assign stat.top_ge   = (code_prio(rd_reg) >= code_prio(in_code));
    assign stat.can_emit = !pend_valid_reg || !out_valid_reg || res_ch.ready;

    assign res_ch.valid          = out_valid_reg;
    assign res_ch.out_symbol     = out_sym_reg;
    assign res_ch.fault          = out_fault_reg;
    assign res_ch.run_end        = out_run_end_reg;
    assign res_ch.expression_end = out_expr_end_reg;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - infix to postfix converter check
// Feeds infix character streams (hand-written cases, random well-formed
// expressions, deep bracket nests and noise) through the character channel,
// predicts the postfix results with a local shunting-yard model and checks
// every result request against it under several idle and stall mixes.
// ----------------------------------------------------------------------------
module testbench;

    import itpc_pkg::*;

    localparam int unsigned STACK_DEPTH = DEF_STACK_DEPTH;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned TAIL_CYCLES = 100;   // room for the longest flush, a full stack
    localparam int unsigned PHASE_ITEMS = 90;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct packed {
        sym_t symbol;
        logic fin;
    } infix_char_t;

    typedef struct packed {
        sym_t   out_symbol;
        fault_t fault;
        logic   run_end;
        logic   expression_end;
    } postfix_res_t;

    logic clk;
    logic rst_n;

    itpc_sym_if sym_ch ();
    itpc_res_if res_ch ();

    infix_to_postfix_converter_unit #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sym_ch (sym_ch),
        .res_ch (res_ch)
    );

    // characters waiting for the driver, and the staging area one expression
    // is built in before it is handed over whole
    infix_char_t  infix_pending[$];
    infix_char_t  expr_buf[$];
    // postfix results predicted but not yet seen
    postfix_res_t postfix_due[$];

    // local copy of the operator stack
    op_code_t     op_stack [STACK_DEPTH];
    int unsigned  op_count;

    int unsigned  send_idle_pct;
    int unsigned  recv_stall_pct;

    int unsigned  chars_sent     = 0;
    int unsigned  results_seen   = 0;
    int unsigned  unmatched_seen = 0;
    int unsigned  overflow_seen  = 0;
    int unsigned  run_len        = 0;
    int unsigned  longest_run    = 0;
    int unsigned  mismatches     = 0;
    int unsigned  cycle_count    = 0;

    // ------------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------------
    initial clk = 1'b0;

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, postfix_due.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Shunting-yard predictor
    // ------------------------------------------------------------------------
    function automatic prio_t rank(input op_code_t code);
        if (code == CODE_OPEN)
            return PRIO_OPEN;
        if (code == CODE_MUL || code == CODE_DIV)
            return PRIO_MUL;
        return PRIO_ADD;
    endfunction

    function automatic sym_t glyph(input op_code_t code);
        case (code)
            CODE_ADD:  return CH_ADD;
            CODE_SUB:  return CH_SUB;
            CODE_MUL:  return CH_MUL;
            CODE_DIV:  return CH_DIV;
            CODE_OPEN: return CH_OPEN;
            default:   return CH_NONE;
        endcase
    endfunction

    function automatic postfix_res_t mk_res(input sym_t s, input fault_t f);
        postfix_res_t r;
        r.out_symbol     = s;
        r.fault          = f;
        r.run_end        = 1'b0;
        r.expression_end = 1'b0;
        return r;
    endfunction

    // push onto the local stack; a full stack drops the entry
    task automatic stack_push(input op_code_t code, output logic overflow);
        overflow = (op_count >= STACK_DEPTH);
        if (!overflow)
        begin
            op_stack[op_count] = code;
            op_count++;
        end
    endtask

    // works out every result one accepted character releases
    task automatic predict_postfix(input infix_char_t ch);
        postfix_res_t batch[$];
        op_code_t     code;
        op_code_t     top;
        logic         found;
        logic         ovf;
        begin
            if (ch.symbol == CH_OPEN)
            begin
                stack_push(CODE_OPEN, ovf);
                if (ovf)
                    batch.push_back(mk_res(CH_NONE, FAULT_OVERFLOW));
            end
            else if (ch.symbol == CH_CLOSE)
            begin
                // pop down to the matching bracket, which is dropped
                found = 1'b0;
                while (op_count > 0 && !found)
                begin
                    op_count--;
                    top = op_stack[op_count];
                    if (top == CODE_OPEN)
                        found = 1'b1;
                    else
                        batch.push_back(mk_res(glyph(top), FAULT_NONE));
                end
                if (!found)
                    batch.push_back(mk_res(CH_NONE, FAULT_UNMATCHED));
            end
            else if (ch.symbol == CH_ADD || ch.symbol == CH_SUB ||
                     ch.symbol == CH_MUL || ch.symbol == CH_DIV)
            begin
                case (ch.symbol)
                    CH_ADD:  code = CODE_ADD;
                    CH_SUB:  code = CODE_SUB;
                    CH_MUL:  code = CODE_MUL;
                    default: code = CODE_DIV;
                endcase
                // equal or higher priority leaves first
                while (op_count > 0 && rank(op_stack[op_count - 1]) >= rank(code))
                begin
                    op_count--;
                    batch.push_back(mk_res(glyph(op_stack[op_count]), FAULT_NONE));
                end
                stack_push(code, ovf);
                if (ovf)
                    batch.push_back(mk_res(CH_NONE, FAULT_OVERFLOW));
            end
            else
            begin
                batch.push_back(mk_res(ch.symbol, FAULT_NONE));
            end

            // last character: everything left goes out top first, brackets too
            if (ch.fin)
            begin
                while (op_count > 0)
                begin
                    op_count--;
                    batch.push_back(mk_res(glyph(op_stack[op_count]), FAULT_NONE));
                end
            end

            if (batch.size() > 0)
            begin
                batch[batch.size() - 1].run_end        = 1'b1;
                batch[batch.size() - 1].expression_end = ch.fin;
            end
            foreach (batch[i])
                postfix_due.push_back(batch[i]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents the oldest pending character, holds it until taken
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_ch.valid      <= 1'b0;
            sym_ch.symbol     <= CH_NONE;
            sym_ch.final_char <= 1'b0;
            op_count          = 0;
        end
        else
        begin
            if (sym_ch.valid && sym_ch.ready)
            begin
                predict_postfix(infix_pending[0]);
                infix_pending.pop_front();
                chars_sent <= chars_sent + 1;
            end

            if (sym_ch.valid && !sym_ch.ready)
            begin
                // request still open, payload stays put
            end
            else if (infix_pending.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                sym_ch.valid      <= 1'b1;
                sym_ch.symbol     <= infix_pending[0].symbol;
                sym_ch.final_char <= infix_pending[0].fin;
            end
            else
            begin
                sym_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: random back-pressure, checks each result against the oldest
    // prediction
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        postfix_res_t got;
        postfix_res_t want;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got.out_symbol     = res_ch.out_symbol;
                got.fault          = res_ch.fault;
                got.run_end        = res_ch.run_end;
                got.expression_end = res_ch.expression_end;
                results_seen <= results_seen + 1;
                if (got.fault == FAULT_UNMATCHED)
                    unmatched_seen <= unmatched_seen + 1;
                if (got.fault == FAULT_OVERFLOW)
                    overflow_seen <= overflow_seen + 1;
                if (got.run_end === 1'b1)
                begin
                    if (run_len + 1 > longest_run)
                        longest_run <= run_len + 1;
                    run_len <= 0;
                end
                else
                begin
                    run_len <= run_len + 1;
                end

                if (postfix_due.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected result: sym %h fault %0d run_end %b expr_end %b",
                                 got.out_symbol, got.fault, got.run_end,
                                 got.expression_end);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = postfix_due.pop_front();
                    if (got.out_symbol !== want.out_symbol || got.fault !== want.fault ||
                        got.run_end !== want.run_end ||
                        got.expression_end !== want.expression_end)
                    begin
                        if (mismatches < MAX_REPORTS)
                            $display("result %0d: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                                     results_seen, want.out_symbol, want.fault,
                                     want.run_end, want.expression_end, got.out_symbol,
                                     got.fault, got.run_end, got.expression_end);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    function automatic sym_t plain_char();
        sym_t c;
        c = sym_t'($urandom_range(255));
        while (c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV ||
               c == CH_OPEN || c == CH_CLOSE)
            c = sym_t'($urandom_range(255));
        return c;
    endfunction

    function automatic sym_t pick_operator();
        case ($urandom_range(3))
            0:       return CH_ADD;
            1:       return CH_SUB;
            2:       return CH_MUL;
            default: return CH_DIV;
        endcase
    endfunction

    task automatic stage(input sym_t s, input logic fin);
        infix_char_t c;
        c.symbol = s;
        c.fin    = fin;
        expr_buf.push_back(c);
    endtask

    // hand the staged characters to the driver, optionally marking the last
    // one as the end of the expression
    task automatic commit_expr(input logic mark_final);
        if (mark_final && expr_buf.size() > 0)
            expr_buf[expr_buf.size() - 1].fin = 1'b1;
        foreach (expr_buf[i])
            infix_pending.push_back(expr_buf[i]);
        expr_buf.delete();
    endtask

    // well-formed infix expression with random operands, operators and nesting
    task automatic add_expression(input int unsigned max_depth, input int unsigned operands);
        int unsigned depth;
        int unsigned n;
        depth = 0;
        for (n = 0; n < operands; n++)
        begin
            while (depth < max_depth && $urandom_range(3) == 0)
            begin
                stage(CH_OPEN, 1'b0);
                depth++;
            end
            stage(plain_char(), 1'b0);
            while (depth > 0 && $urandom_range(2) == 0)
            begin
                stage(CH_CLOSE, 1'b0);
                depth--;
            end
            if (n + 1 < operands)
                stage(pick_operator(), 1'b0);
        end
        while (depth > 0)
        begin
            stage(CH_CLOSE, 1'b0);
            depth--;
        end
        commit_expr(1'b1);
    endtask

    // bracket nest near or past the stack depth
    task automatic add_deep(input int unsigned levels);
        int unsigned i;
        for (i = 0; i < levels; i++)
            stage(CH_OPEN, 1'b0);
        stage(plain_char(), 1'b0);
        for (i = $urandom_range(2); i > 0; i--)
        begin
            stage(pick_operator(), 1'b0);
            stage(plain_char(), 1'b0);
        end
        for (i = $urandom_range(levels); i > 0; i--)
            stage(CH_CLOSE, 1'b0);
        commit_expr(1'b1);
    endtask

    // arbitrary characters, stray brackets and random end marks
    task automatic add_noise(input int unsigned count);
        int unsigned i;
        sym_t        s;
        for (i = 0; i < count; i++)
        begin
            case ($urandom_range(7))
                0:       s = CH_OPEN;
                1:       s = CH_CLOSE;
                2, 3:    s = pick_operator();
                default: s = sym_t'($urandom_range(255));
            endcase
            stage(s, $urandom_range(7) == 0);
        end
        commit_expr(1'b0);
    endtask

    // sender holds off until every predicted result has arrived
    task automatic drain();
        while (infix_pending.size() != 0 || postfix_due.size() != 0 || sym_ch.valid)
            @(posedge clk);
    endtask

    task automatic random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
        int unsigned target;
        int unsigned r;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = infix_pending.size() + PHASE_ITEMS;
        while (infix_pending.size() < target)
        begin
            r = $urandom_range(99);
            if (r < 6)
                add_deep($urandom_range(28, 36));
            else if (r < 80)
                add_expression($urandom_range(4), $urandom_range(1, 6));
            else
                add_noise($urandom_range(1, 8));
        end
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (2) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // byte extremes as operands
        stage(8'h00, 1'b0);
        stage(8'hFF, 1'b1);
        // priorities: equal and higher priority pops, all four operators
        stage("a", 1'b0); stage(CH_ADD, 1'b0); stage("b", 1'b0); stage(CH_MUL, 1'b0);
        stage("c", 1'b0); stage(CH_SUB, 1'b0); stage("d", 1'b0); stage(CH_DIV, 1'b0);
        stage("e", 1'b1);
        // bracketed sum
        stage(CH_OPEN, 1'b0); stage("a", 1'b0); stage(CH_ADD, 1'b0); stage("b", 1'b0);
        stage(CH_CLOSE, 1'b0); stage(CH_MUL, 1'b0); stage("c", 1'b1);
        // unmatched close bracket, alone and after a pending operator
        stage(CH_CLOSE, 1'b1);
        stage("a", 1'b0); stage(CH_ADD, 1'b0); stage("b", 1'b0); stage(CH_CLOSE, 1'b1);
        // open bracket left over at the flush; end mark on an operator and a bracket
        stage(CH_OPEN, 1'b0); stage("a", 1'b1);
        stage("a", 1'b0); stage(CH_MUL, 1'b1);
        stage(CH_OPEN, 1'b1);
        commit_expr(1'b0);
        // stack overflow on a bracket and on an operator, then the longest flush
        for (int i = 0; i < STACK_DEPTH + 1; i++)
            stage(CH_OPEN, 1'b0);
        stage(CH_DIV, 1'b0);
        stage("x", 1'b1);
        commit_expr(1'b0);
        drain();

        random_phase(0, 0);
        random_phase(85, 0);
        random_phase(0, 85);
        random_phase(18, 18);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (postfix_due.size() != 0)
            $display("%0d predicted results never arrived", postfix_due.size());

        $display("%0d characters in, %0d postfix results out, longest run %0d",
                 chars_sent, results_seen, longest_run);
        $display("fault reports: %0d unmatched bracket, %0d stack overflow; %0d mismatches",
                 unmatched_seen, overflow_seen, mismatches);
        if (mismatches == 0 && postfix_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
